[hw/rtl/cfrd_pkg.sv]
`default_nettype none

package cfrd_pkg;

    // Request codes on the input side (tuser)
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_DATA   = 2'd2;

    // Control-port status codes
    localparam logic [7:0] ST_IDLE = 8'd0;
    localparam logic [7:0] ST_DATA = 8'd1;
    localparam logic [7:0] ST_EOF  = 8'd2;
    localparam logic [7:0] ST_BUSY = 8'd3;
    localparam logic [7:0] ST_ERR  = 8'd255;

    // Result kinds (output tuser)
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_OK   = 2'd2;
    localparam logic [1:0] KIND_FAIL = 2'd3;

    // Port commands issued
    localparam logic [7:0] PCMD_GETCH = 8'd3;
    localparam logic [7:0] PCMD_CLOSE = 8'd4;

    // Text conversion bytes
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_EOT = 8'd26;

    localparam int PAD_W = 7;
    localparam int CNT_W = 32;
    localparam int MAX_RES = 3;

    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_AWAIT_OPEN = 8'b0000_0010,
        PH_AWAIT_CHNK = 8'b0000_0100,
        PH_READ_LEN   = 8'b0000_1000,
        PH_PAYLOAD    = 8'b0001_0000,
        PH_CHECK      = 8'b0010_0000,
        PH_DONE       = 8'b0100_0000,
        PH_FAILED     = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } entry_t;

    // All results caused by one request; pad/total belong to a finish result,
    // which is always the last one.
    typedef struct packed {
        logic [1:0]             count;
        entry_t [MAX_RES-1:0]   entry;
        logic [PAD_W-1:0]       pad;
        logic [CNT_W-1:0]       total;
    } bundle_t;

endpackage

`default_nettype wire

[hw/rtl/chunked_file_receive_deframer.sv]
`default_nettype none

// Receive deframer for a polled, chunked file-transfer link. Each slave request is
// one port read (tuser: 0 start, 1 control status, 2 data byte; tdata: the value
// read). The block waits out busy status, asks for chunks, reads the length byte
// (0 = full chunk) and the payload, converts line endings in text mode, and at end
// of file issues close, a ^Z in text mode and a finish result carrying the NUL pad
// for the last record and the saturating payload count. One request is taken per
// cycle while the buffer has room: its results are worked out in one pass and
// queued as a bundle of up to three results in a two-deep bundle buffer; the first
// of them shows on the master side after passing the hold and current registers.
// The master side sends one result per cycle while m_tready is high, so the output
// port sets the sustained rate (one request per cycle while each causes at most one
// result). Requests with no result are not queued, but like every request they
// wait while both bundle slots are taken. The mode register may be written only
// while no results are in flight.

module chunked_file_receive_deframer #(
    parameter int CHUNK_MAX    = 256,
    parameter int RECORD_BYTES = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,      // binary_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,        // [7:0] port_value
    input  wire logic [1:0]  s_tuser,        // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,        // [7:0] out_value, [14:8] pad_count,
                                             // [46:15] received_count, [47] zero
    output logic [1:0]       m_tuser,        // [1:0] result_kind
    output logic             m_tlast         // last_of_run
);

    localparam int BL_W = $clog2(CHUNK_MAX + 1);
    localparam int WM_W = $clog2(RECORD_BYTES);

    cfrd_pkg::phase_t               phase_reg;
    cfrd_pkg::phase_t               phase_next;
    logic [BL_W-1:0]                bytes_left_reg;
    logic [BL_W-1:0]                bytes_left_next;
    logic [WM_W-1:0]                wmr_reg;
    logic [WM_W-1:0]                wmr_next;
    logic [cfrd_pkg::CNT_W-1:0]     total_reg;
    logic [cfrd_pkg::CNT_W-1:0]     total_next;
    logic                           binary_mode_reg;
    cfrd_pkg::bundle_t              bundle;
    logic                           accept;
    logic [cfrd_pkg::PAD_W-1:0]     out_pad;
    logic [cfrd_pkg::CNT_W-1:0]     out_total;
    logic [7:0]                     out_value;

    assign accept = s_tvalid && s_tready;

    // Phase update and result bundle for the request on the slave side
    cfrd_step #(
        .CHUNK_MAX    (CHUNK_MAX),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_step (
        .phase           (phase_reg),
        .bytes_left      (bytes_left_reg),
        .wmr             (wmr_reg),
        .total           (total_reg),
        .binary_mode     (binary_mode_reg),
        .command         (s_tuser),
        .port_value      (s_tdata),
        .phase_next      (phase_next),
        .bytes_left_next (bytes_left_next),
        .wmr_next        (wmr_next),
        .total_next      (total_next),
        .bundle          (bundle)
    );

    // Bundle buffer and one-result-per-cycle serialiser (while out_ready is high)
    cfrd_drain u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept && (bundle.count != 2'd0)),
        .push_bundle (bundle),
        .push_ready  (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_value   (out_value),
        .out_pad     (out_pad),
        .out_total   (out_total),
        .out_last    (m_tlast)
    );

    assign m_tdata = {1'b0, out_total, out_pad, out_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= cfrd_pkg::PH_IDLE;
            bytes_left_reg  <= '0;
            wmr_reg         <= '0;
            total_reg       <= '0;
            binary_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                binary_mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                wmr_reg        <= wmr_next;
                total_reg      <= total_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cfrd_step.sv]
`default_nettype none

module cfrd_step #(
    parameter int CHUNK_MAX    = 256,
    parameter int RECORD_BYTES = 128
) (
    input  wire cfrd_pkg::phase_t                     phase,
    input  wire logic [$clog2(CHUNK_MAX+1)-1:0]       bytes_left,
    input  wire logic [$clog2(RECORD_BYTES)-1:0]      wmr,
    input  wire logic [cfrd_pkg::CNT_W-1:0]           total,
    input  wire logic                                 binary_mode,
    input  wire logic [1:0]                           command,
    input  wire logic [7:0]                           port_value,
    output cfrd_pkg::phase_t                          phase_next,
    output logic [$clog2(CHUNK_MAX+1)-1:0]            bytes_left_next,
    output logic [$clog2(RECORD_BYTES)-1:0]           wmr_next,
    output logic [cfrd_pkg::CNT_W-1:0]                total_next,
    output cfrd_pkg::bundle_t                         bundle
);

    localparam int BL_W  = $clog2(CHUNK_MAX + 1);
    localparam int WM_W  = $clog2(RECORD_BYTES);
    localparam int SUM_W = WM_W + 2;
    localparam int PF_W  = (WM_W + 1 > cfrd_pkg::PAD_W) ? WM_W + 1 : cfrd_pkg::PAD_W;

    logic [SUM_W-1:0] wsum;
    logic [SUM_W-1:0] wsum_wr;
    logic [WM_W-1:0]  wmr_eot;
    logic [PF_W-1:0]  pad_full;
    logic [8:0]       len9;
    logic [BL_W-1:0]  bl_dec;
    logic [1:0]       nwr;

    // Record position after a finish (past the ^Z marker in text mode) and the NUL pad for the last record
    always_comb
    begin
        wsum = SUM_W'(wmr) + SUM_W'(1);
        if (wsum >= SUM_W'(RECORD_BYTES))
        begin
            wsum = wsum - SUM_W'(RECORD_BYTES);
        end
        wmr_eot = binary_mode ? wmr : wsum[WM_W-1:0];
        pad_full = (wmr_eot == '0) ? '0 : (PF_W'(RECORD_BYTES) - PF_W'(wmr_eot));
    end

    always_comb
    begin
        phase_next      = phase;
        bytes_left_next = bytes_left;
        wmr_next        = wmr;
        total_next      = total;
        bundle          = '0;
        len9            = '0;
        bl_dec          = bytes_left;
        nwr             = 2'd0;
        wsum_wr         = '0;

        case (command)
            cfrd_pkg::CMD_START:
            begin
                phase_next      = cfrd_pkg::PH_AWAIT_OPEN;
                bytes_left_next = '0;
                wmr_next        = '0;
                total_next      = '0;
            end

            cfrd_pkg::CMD_STATUS:
            begin
                if ((phase == cfrd_pkg::PH_AWAIT_OPEN) && (port_value == cfrd_pkg::ST_ERR))
                begin
                    bundle.count          = 2'd1;
                    bundle.entry[0].kind  = cfrd_pkg::KIND_FAIL;
                    phase_next            = cfrd_pkg::PH_FAILED;
                end
                else if ((phase == cfrd_pkg::PH_AWAIT_OPEN) && (port_value != cfrd_pkg::ST_BUSY))
                begin
                    bundle.count          = 2'd1;
                    bundle.entry[0].kind  = cfrd_pkg::KIND_CMD;
                    bundle.entry[0].value = cfrd_pkg::PCMD_GETCH;
                    phase_next            = cfrd_pkg::PH_AWAIT_CHNK;
                end
                else if ((phase == cfrd_pkg::PH_AWAIT_CHNK || phase == cfrd_pkg::PH_CHECK)
                         && port_value == cfrd_pkg::ST_EOF)
                begin
                    // close, optional ^Z, finish
                    bundle.entry[0].kind  = cfrd_pkg::KIND_CMD;
                    bundle.entry[0].value = cfrd_pkg::PCMD_CLOSE;
                    bundle.pad            = pad_full[cfrd_pkg::PAD_W-1:0];
                    bundle.total          = total;
                    wmr_next              = wmr_eot;
                    phase_next            = cfrd_pkg::PH_DONE;
                    if (binary_mode)
                    begin
                        bundle.count         = 2'd2;
                        bundle.entry[1].kind = cfrd_pkg::KIND_OK;
                    end
                    else
                    begin
                        bundle.count          = 2'd3;
                        bundle.entry[1].kind  = cfrd_pkg::KIND_BYTE;
                        bundle.entry[1].value = cfrd_pkg::CH_EOT;
                        bundle.entry[2].kind  = cfrd_pkg::KIND_OK;
                    end
                end
                else if ((phase == cfrd_pkg::PH_AWAIT_CHNK || phase == cfrd_pkg::PH_CHECK)
                         && port_value == cfrd_pkg::ST_ERR)
                begin
                    bundle.count          = 2'd2;
                    bundle.entry[0].kind  = cfrd_pkg::KIND_CMD;
                    bundle.entry[0].value = cfrd_pkg::PCMD_CLOSE;
                    bundle.entry[1].kind  = cfrd_pkg::KIND_FAIL;
                    phase_next            = cfrd_pkg::PH_FAILED;
                end
                else if ((phase == cfrd_pkg::PH_AWAIT_CHNK) && (port_value == cfrd_pkg::ST_DATA))
                begin
                    phase_next = cfrd_pkg::PH_READ_LEN;
                end
                else if (phase == cfrd_pkg::PH_CHECK)
                begin
                    bundle.count          = 2'd1;
                    bundle.entry[0].kind  = cfrd_pkg::KIND_CMD;
                    bundle.entry[0].value = cfrd_pkg::PCMD_GETCH;
                    phase_next            = cfrd_pkg::PH_AWAIT_CHNK;
                end
            end

            cfrd_pkg::CMD_DATA:
            begin
                if (phase == cfrd_pkg::PH_READ_LEN)
                begin
                    // zero means a full chunk; clamp to the chunk limit
                    len9 = (port_value == 8'd0) ? 9'(CHUNK_MAX) : {1'b0, port_value};
                    if (len9 > 9'(CHUNK_MAX))
                    begin
                        len9 = 9'(CHUNK_MAX);
                    end
                    bytes_left_next = len9[BL_W-1:0];
                    phase_next      = cfrd_pkg::PH_PAYLOAD;
                end
                else if (phase == cfrd_pkg::PH_PAYLOAD)
                begin
                    if (total != {cfrd_pkg::CNT_W{1'b1}})
                    begin
                        total_next = total + cfrd_pkg::CNT_W'(1);
                    end
                    if (!binary_mode && port_value == cfrd_pkg::CH_LF)
                    begin
                        bundle.count          = 2'd2;
                        bundle.entry[0].kind  = cfrd_pkg::KIND_BYTE;
                        bundle.entry[0].value = cfrd_pkg::CH_CR;
                        bundle.entry[1].kind  = cfrd_pkg::KIND_BYTE;
                        bundle.entry[1].value = cfrd_pkg::CH_LF;
                        nwr                   = 2'd2;
                    end
                    else if (binary_mode || port_value != cfrd_pkg::CH_CR)
                    begin
                        bundle.count          = 2'd1;
                        bundle.entry[0].kind  = cfrd_pkg::KIND_BYTE;
                        bundle.entry[0].value = port_value;
                        nwr                   = 2'd1;
                    end
                    wsum_wr = SUM_W'(wmr) + SUM_W'(nwr);
                    if (wsum_wr >= SUM_W'(RECORD_BYTES))
                    begin
                        wsum_wr = wsum_wr - SUM_W'(RECORD_BYTES);
                    end
                    wmr_next = wsum_wr[WM_W-1:0];
                    if (bytes_left != '0)
                    begin
                        bl_dec = bytes_left - BL_W'(1);
                    end
                    bytes_left_next = bl_dec;
                    if (bl_dec == '0)
                    begin
                        phase_next = cfrd_pkg::PH_CHECK;
                    end
                end
            end

            default:
            begin
                phase_next = phase;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/cfrd_drain.sv]
`default_nettype none

module cfrd_drain (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cfrd_pkg::bundle_t  push_bundle,
    output logic                    push_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              out_kind,
    output logic [7:0]              out_value,
    output logic [cfrd_pkg::PAD_W-1:0] out_pad,
    output logic [cfrd_pkg::CNT_W-1:0] out_total,
    output logic                    out_last
);

    cfrd_pkg::bundle_t hold_reg;
    cfrd_pkg::bundle_t cur_reg;
    logic              hold_vld_reg;
    logic              cur_vld_reg;
    logic [1:0]        idx_reg;
    cfrd_pkg::entry_t  sel;
    logic              pop_last;
    logic              cur_free;
    logic              move;

    always_comb
    begin
        case (idx_reg)
            2'd1:    sel = cur_reg.entry[1];
            2'd2:    sel = cur_reg.entry[2];
            default: sel = cur_reg.entry[0];
        endcase
    end

    assign out_last   = (idx_reg == cur_reg.count - 2'd1);
    assign pop_last   = cur_vld_reg && out_ready && out_last;
    assign cur_free   = !cur_vld_reg || pop_last;
    assign move       = hold_vld_reg && cur_free;
    assign push_ready = !hold_vld_reg || cur_free;

    assign out_valid = cur_vld_reg;
    assign out_kind  = sel.kind;
    assign out_value = sel.value;
    assign out_pad   = (sel.kind == cfrd_pkg::KIND_OK) ? cur_reg.pad : '0;
    assign out_total = (sel.kind == cfrd_pkg::KIND_OK) ? cur_reg.total : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            cur_vld_reg  <= 1'b0;
            idx_reg      <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                hold_vld_reg <= 1'b1;
            end
            else if (move)
            begin
                hold_vld_reg <= 1'b0;
            end

            if (move)
            begin
                cur_vld_reg <= 1'b1;
                idx_reg     <= 2'd0;
            end
            else if (pop_last)
            begin
                cur_vld_reg <= 1'b0;
            end
            else if (cur_vld_reg && out_ready)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hold_reg <= push_bundle;
        end
        if (move)
        begin
            cur_reg <= hold_reg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cfrd_checker.sv]
`default_nettype none

module cfrd_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // finish and fail always end a run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == cfrd_pkg::KIND_OK || m_tuser == cfrd_pkg::KIND_FAIL)
        |-> m_tlast)
        else $error("terminal result without tlast");

    // pad and count only on a finish
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != cfrd_pkg::KIND_OK |-> m_tdata[47:8] == '0)
        else $error("pad or count on a non-finish result");

    // commands are only request-chunk or close
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cfrd_pkg::KIND_CMD
        |-> (m_tdata[7:0] == cfrd_pkg::PCMD_GETCH || m_tdata[7:0] == cfrd_pkg::PCMD_CLOSE))
        else $error("bad command code");

    // a close command is never the end of a run
    a_close_more: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cfrd_pkg::KIND_CMD && m_tdata[7:0] == cfrd_pkg::PCMD_CLOSE
        |-> !m_tlast)
        else $error("close without following result");

endmodule

bind chunked_file_receive_deframer cfrd_port_checker u_cfrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
